// File: rtl/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
// No dependencies; used by every module in rtl/ except tcpq_ram.
package tcpq_pkg;

  localparam int unsigned CAPACITY = 16;

  localparam int unsigned CODE_W   = 16;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned WORD_W   = CODE_W + AGE_W;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    set_result;
    status_e status;
    logic    wr_high;
    logic    wr_low;
    logic    rd_high;
    logic    rd_low;
    logic    load_word;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic high_any;
    logic low_any;
  } stat_t;

endpackage

// File: rtl/tcpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcpq_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcpq_ctrl.sv
// Request sequencer: accepts a request, issues datapath commands, holds the result.
// Depends on tcpq_pkg.
module tcpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic            entry_high_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  tcpq_pkg::stat_t stat_i,
  output tcpq_pkg::cmd_t  cmd_o
);

  tcpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.status = tcpq_pkg::ST_ENQUEUED;
    unique case (state_q)
      tcpq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.set_result = 1'b1;
          state_d = tcpq_pkg::S_RESP;
          if (req_type_i == tcpq_pkg::REQ_ENQ) begin
            if (stat_i.full) begin
              cmd_o.status = tcpq_pkg::ST_FULL;
            end else begin
              cmd_o.status  = tcpq_pkg::ST_ENQUEUED;
              cmd_o.wr_high = entry_high_i;
              cmd_o.wr_low  = !entry_high_i;
            end
          end else if (stat_i.high_any) begin
            cmd_o.status  = tcpq_pkg::ST_SERVED;
            cmd_o.rd_high = 1'b1;
            state_d       = tcpq_pkg::S_READ;
          end else if (stat_i.low_any) begin
            cmd_o.status = tcpq_pkg::ST_SERVED;
            cmd_o.rd_low = 1'b1;
            state_d      = tcpq_pkg::S_READ;
          end else begin
            cmd_o.status = tcpq_pkg::ST_EMPTY;
          end
        end
      end
      tcpq_pkg::S_READ: begin
        cmd_o.load_word = 1'b1;
        state_d         = tcpq_pkg::S_RESP;
      end
      tcpq_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = tcpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tcpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/tcpq_dpath.sv
// Datapath: per-class stores, head/tail pointers, counts and result registers.
// Depends on tcpq_pkg and tcpq_ram.
module tcpq_dpath #(
  parameter int unsigned CAPACITY = tcpq_pkg::CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tcpq_pkg::cmd_t                  cmd_i,
  output tcpq_pkg::stat_t                 stat_o,
  input  logic [tcpq_pkg::CODE_W-1:0]     entry_code_i,
  input  logic [tcpq_pkg::AGE_W-1:0]      entry_age_i,
  output logic [tcpq_pkg::STATUS_W-1:0]   status_o,
  output logic [tcpq_pkg::CODE_W-1:0]     served_code_o,
  output logic [tcpq_pkg::AGE_W-1:0]      served_age_o,
  output logic                            served_high_o,
  output logic [tcpq_pkg::OCC_W-1:0]      occupancy_o
);

  localparam int unsigned PtrW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = (CntW + 1 > tcpq_pkg::OCC_W) ? CntW + 1 : tcpq_pkg::OCC_W;
  localparam logic [PtrW-1:0] LastPos = PtrW'(CAPACITY - 1);

  logic [PtrW-1:0] high_head_q, high_head_d, high_tail_q, high_tail_d;
  logic [PtrW-1:0] low_head_q, low_head_d, low_tail_q, low_tail_d;
  logic [CntW-1:0] high_cnt_q, high_cnt_d, low_cnt_q, low_cnt_d;
  logic [SumW-1:0] total_now, total_next;

  logic [tcpq_pkg::WORD_W-1:0] wdata;
  logic [tcpq_pkg::WORD_W-1:0] high_rdata, low_rdata;
  logic [tcpq_pkg::WORD_W-1:0] word_q;
  tcpq_pkg::status_e           status_q;
  logic                        served_high_q;
  logic [tcpq_pkg::OCC_W-1:0]  occ_q;

  function automatic logic [PtrW-1:0] next_pos(input logic [PtrW-1:0] p);
    next_pos = (p == LastPos) ? '0 : p + PtrW'(1);
  endfunction

  assign wdata = {entry_code_i, entry_age_i};

  tcpq_ram #(
    .WIDTH(tcpq_pkg::WORD_W),
    .DEPTH(CAPACITY)
  ) u_high_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_high),
    .waddr_i(high_tail_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_high),
    .raddr_i(high_head_q),
    .rdata_o(high_rdata)
  );

  tcpq_ram #(
    .WIDTH(tcpq_pkg::WORD_W),
    .DEPTH(CAPACITY)
  ) u_low_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_low),
    .waddr_i(low_tail_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_low),
    .raddr_i(low_head_q),
    .rdata_o(low_rdata)
  );

  always_comb begin
    high_head_d = cmd_i.rd_high ? next_pos(high_head_q) : high_head_q;
    high_tail_d = cmd_i.wr_high ? next_pos(high_tail_q) : high_tail_q;
    low_head_d  = cmd_i.rd_low  ? next_pos(low_head_q)  : low_head_q;
    low_tail_d  = cmd_i.wr_low  ? next_pos(low_tail_q)  : low_tail_q;

    high_cnt_d = high_cnt_q;
    if (cmd_i.wr_high) begin
      high_cnt_d = high_cnt_q + CntW'(1);
    end else if (cmd_i.rd_high) begin
      high_cnt_d = high_cnt_q - CntW'(1);
    end
    low_cnt_d = low_cnt_q;
    if (cmd_i.wr_low) begin
      low_cnt_d = low_cnt_q + CntW'(1);
    end else if (cmd_i.rd_low) begin
      low_cnt_d = low_cnt_q - CntW'(1);
    end

    total_now  = SumW'(high_cnt_q) + SumW'(low_cnt_q);
    total_next = SumW'(high_cnt_d) + SumW'(low_cnt_d);
  end

  assign stat_o.full     = (total_now >= SumW'(CAPACITY));
  assign stat_o.high_any = (high_cnt_q != '0);
  assign stat_o.low_any  = (low_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_head_q <= '0;
      high_tail_q <= '0;
      low_head_q  <= '0;
      low_tail_q  <= '0;
      high_cnt_q  <= '0;
      low_cnt_q   <= '0;
    end else begin
      high_head_q <= high_head_d;
      high_tail_q <= high_tail_d;
      low_head_q  <= low_head_d;
      low_tail_q  <= low_tail_d;
      high_cnt_q  <= high_cnt_d;
      low_cnt_q   <= low_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_result) begin
      status_q      <= cmd_i.status;
      served_high_q <= cmd_i.rd_high;
      occ_q         <= total_next[tcpq_pkg::OCC_W-1:0];
      word_q        <= '0;
    end else if (cmd_i.load_word) begin
      word_q <= served_high_q ? high_rdata : low_rdata;
    end
  end

  assign status_o      = tcpq_pkg::STATUS_W'(status_q);
  assign served_code_o = word_q[tcpq_pkg::WORD_W-1:tcpq_pkg::AGE_W];
  assign served_age_o  = word_q[tcpq_pkg::AGE_W-1:0];
  assign served_high_o = served_high_q;
  assign occupancy_o   = occ_q;

endmodule

// File: rtl/two_class_priority_queue_core.sv
// Two-class strict priority queue: sequencer plus datapath with one store per class.
// Enqueue, full and empty results are registered as the request is taken and are
// valid in the cycle after; a serve result is loaded in S_READ (registered store read)
// and is valid in S_RESP. One request at a time: the next is taken once the result is
// taken. Reset clears pointers, counts and the sequencer; store contents stay undefined
// and are only read after being written. Depends on tcpq_pkg, tcpq_ctrl, tcpq_dpath.
module two_class_priority_queue_core #(
  parameter int unsigned CAPACITY = tcpq_pkg::CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [tcpq_pkg::CODE_W-1:0]   entry_code_i,
  input  logic [tcpq_pkg::AGE_W-1:0]    entry_age_i,
  input  logic                          entry_high_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcpq_pkg::STATUS_W-1:0] status_o,
  output logic [tcpq_pkg::CODE_W-1:0]   served_code_o,
  output logic [tcpq_pkg::AGE_W-1:0]    served_age_o,
  output logic                          served_high_o,
  output logic [tcpq_pkg::OCC_W-1:0]    occupancy_o
);

  tcpq_pkg::cmd_t  cmd;
  tcpq_pkg::stat_t stat;

  tcpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .entry_high_i(entry_high_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcpq_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .entry_code_i (entry_code_i),
    .entry_age_i  (entry_age_i),
    .status_o     (status_o),
    .served_code_o(served_code_o),
    .served_age_o (served_age_o),
    .served_high_o(served_high_o),
    .occupancy_o  (occupancy_o)
  );

endmodule
